// ===== hw/rtl/gmi_pkg.sv =====
// Shared types, constants and codes for the genetic map interpolator.
`default_nettype none

package gmi_pkg;

    localparam int MAP_DEPTH = 4096;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int CNT_W     = $clog2(MAP_DEPTH + 1);

    localparam int FUNC_W  = 2;
    localparam int POS_W   = 31;
    localparam int GEN_W   = 32;
    localparam int ST_W    = 3;
    localparam int ENTRY_W = POS_W + GEN_W;

    // Interpolation arithmetic: magnitudes of the genetic step, the query offset and the
    // segment width, the full product, and the final signed sum.
    localparam int DG_W    = GEN_W;
    localparam int DX_W    = POS_W;
    localparam int DP_W    = POS_W;
    localparam int PROD_W  = DG_W + DX_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int DIV_CNT_W = $clog2(PROD_W);

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PROD_W - 1);
    localparam logic [CNT_W-1:0]     CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0]     CNT_TWO  = CNT_W'(2);
    localparam logic [CNT_W-1:0]     CNT_FULL = CNT_W'(MAP_DEPTH);

    localparam logic signed [GEN_W-1:0] REJECT_LIMIT = GEN_W'(-32768);
    localparam logic signed [GEN_W-1:0] GEN_MAX      = {1'b0, {(GEN_W-1){1'b1}}};
    localparam logic signed [GEN_W-1:0] GEN_MIN      = {1'b1, {(GEN_W-1){1'b0}}};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [ST_W-1:0] {
        ST_INTERP   = 3'd0,
        ST_BEFORE   = 3'd1,
        ST_PAST     = 3'd2,
        ST_STORED   = 3'd3,
        ST_SKIPPED  = 3'd4,
        ST_REJECTED = 3'd5,
        ST_FULL     = 3'd6,
        ST_FEW      = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_ADD,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_EXEC,
        OP_FIRST,
        OP_SHIFT,
        OP_BEFORE,
        OP_SEG,
        OP_PAST,
        OP_G0,
        OP_MUL,
        OP_DIV,
        OP_ADD,
        OP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic                rd_en;
        logic [ADDR_W-1:0]   rd_addr;
    } t_dp_cmd;

    typedef struct packed {
        logic                is_query;
        logic                few;
        logic                x_le_pa;
        logic                x_le_pb;
        logic                dp_zero;
        logic                out_free;
        logic [CNT_W-1:0]    cnt;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/gmi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gmi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/gmi_ctrl.sv =====
// Control state machine: sequences dispatch, table scan, multiply, divide and result beat.
`default_nettype none

module gmi_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire gmi_pkg::t_dp_stat i_stat,
    output gmi_pkg::t_dp_cmd       o_cmd
);

    gmi_pkg::t_state                   r_state;
    gmi_pkg::t_state                   n_state;
    logic [gmi_pkg::CNT_W-1:0]         r_addr;
    logic [gmi_pkg::DIV_CNT_W-1:0]     r_step;
    gmi_pkg::t_dp_op                   w_scan_op;
    logic                              w_k0;
    logic                              w_k1;
    logic                              w_klast;

    // The entry arriving from the table during the scan is entry r_addr - 1.
    always_comb begin
        w_k0    = (r_addr == gmi_pkg::CNT_ONE);
        w_k1    = (r_addr == gmi_pkg::CNT_TWO);
        w_klast = (r_addr == i_stat.cnt);
        if (w_k0) begin
            w_scan_op = gmi_pkg::OP_FIRST;
        end else if (i_stat.x_le_pa) begin
            w_scan_op = w_k1 ? gmi_pkg::OP_BEFORE : gmi_pkg::OP_G0;
        end else if (i_stat.x_le_pb) begin
            w_scan_op = gmi_pkg::OP_SEG;
        end else if (w_klast) begin
            w_scan_op = gmi_pkg::OP_PAST;
        end else begin
            w_scan_op = gmi_pkg::OP_SHIFT;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gmi_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = gmi_pkg::S_DISPATCH;
                end
            end
            gmi_pkg::S_DISPATCH: begin
                if (i_stat.is_query && !i_stat.few) begin
                    n_state = gmi_pkg::S_SCAN;
                end else begin
                    n_state = gmi_pkg::S_FINISH;
                end
            end
            gmi_pkg::S_SCAN: begin
                case (w_scan_op)
                    gmi_pkg::OP_FIRST, gmi_pkg::OP_SHIFT: n_state = gmi_pkg::S_SCAN;
                    gmi_pkg::OP_G0:                       n_state = gmi_pkg::S_FINISH;
                    default:                              n_state = gmi_pkg::S_MUL;
                endcase
            end
            gmi_pkg::S_MUL: begin
                n_state = i_stat.dp_zero ? gmi_pkg::S_ADD : gmi_pkg::S_DIV;
            end
            gmi_pkg::S_DIV: begin
                if (r_step == gmi_pkg::DIV_LAST) begin
                    n_state = gmi_pkg::S_ADD;
                end
            end
            gmi_pkg::S_ADD: begin
                n_state = gmi_pkg::S_FINISH;
            end
            gmi_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = gmi_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gmi_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.op      = gmi_pkg::OP_NONE;
        o_cmd.rd_en   = 1'b0;
        o_cmd.rd_addr = r_addr[gmi_pkg::ADDR_W-1:0];
        case (r_state)
            gmi_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = gmi_pkg::OP_CAPTURE;
                end
            end
            gmi_pkg::S_DISPATCH: begin
                if (i_stat.is_query && !i_stat.few) begin
                    o_cmd.rd_en = 1'b1;
                end else begin
                    o_cmd.op = gmi_pkg::OP_EXEC;
                end
            end
            gmi_pkg::S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.op    = w_scan_op;
            end
            gmi_pkg::S_MUL: begin
                o_cmd.op = gmi_pkg::OP_MUL;
            end
            gmi_pkg::S_DIV: begin
                o_cmd.op = gmi_pkg::OP_DIV;
            end
            gmi_pkg::S_ADD: begin
                o_cmd.op = gmi_pkg::OP_ADD;
            end
            gmi_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.op = gmi_pkg::OP_FINISH;
                end
            end
            default: begin
                o_cmd.op = gmi_pkg::OP_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gmi_pkg::S_IDLE;
            r_addr  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == gmi_pkg::S_IDLE) begin
                r_addr <= '0;
            end else if (o_cmd.rd_en) begin
                r_addr <= r_addr + gmi_pkg::CNT_ONE;
            end
            if (r_state == gmi_pkg::S_MUL) begin
                r_step <= '0;
            end else if (r_state == gmi_pkg::S_DIV) begin
                r_step <= r_step + gmi_pkg::DIV_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gmi_dp.sv =====
// Datapath: map table, query registers, multiplier, bit-serial divider and output register.
`default_nettype none

module gmi_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire gmi_pkg::t_dp_cmd                  i_cmd,
    output gmi_pkg::t_dp_stat                      o_stat,
    input  wire logic [gmi_pkg::FUNC_W-1:0]        i_func,
    input  wire logic [gmi_pkg::POS_W-1:0]         i_phys_pos,
    input  wire logic signed [gmi_pkg::GEN_W-1:0]  i_map_genetic,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [gmi_pkg::GEN_W-1:0]       o_genetic_out,
    output logic [gmi_pkg::ST_W-1:0]               o_status
);

    localparam int GW = gmi_pkg::GEN_W;
    localparam int PW = gmi_pkg::POS_W;

    gmi_pkg::t_func                    r_func;
    logic [PW-1:0]                     r_x;
    logic signed [GW-1:0]              r_gin;
    logic [gmi_pkg::CNT_W-1:0]         r_cnt;
    logic signed [GW-1:0]              r_last_gen;
    logic [PW-1:0]                     r_prev_phys;
    logic signed [GW-1:0]              r_prev_gen;
    logic [PW-1:0]                     r_pa;
    logic signed [GW-1:0]              r_ga;
    logic signed [GW-1:0]              r_g0;
    logic signed [GW-1:0]              r_base;
    logic                              r_neg;
    logic [gmi_pkg::DG_W-1:0]          r_dg_mag;
    logic [gmi_pkg::DX_W-1:0]          r_dx_mag;
    logic [gmi_pkg::DP_W-1:0]          r_dp_mag;
    logic                              r_dp_zero;
    logic [gmi_pkg::PROD_W-1:0]        r_quo;
    logic [gmi_pkg::DP_W-1:0]          r_rem;
    logic signed [GW-1:0]              r_res;
    gmi_pkg::t_status                  r_st;
    logic                              r_out_valid;
    logic signed [GW-1:0]              r_out_gen;
    gmi_pkg::t_status                  r_out_st;

    logic [gmi_pkg::ENTRY_W-1:0]       w_rd;
    logic [PW-1:0]                     w_rd_phys;
    logic signed [GW-1:0]              w_rd_gen;
    logic                              w_we;
    gmi_pkg::t_status                  w_load_st;
    gmi_pkg::t_status                  w_exec_st;
    logic                              w_past;
    logic signed [GW:0]                w_dg;
    logic signed [GW:0]                w_dg_abs;
    logic [PW-1:0]                     w_xo;
    logic signed [PW:0]                w_dx;
    logic signed [PW:0]                w_dx_abs;
    logic signed [PW:0]                w_dp;
    logic signed [PW:0]                w_dp_abs;
    gmi_pkg::t_status                  w_seg_st;
    logic [gmi_pkg::DP_W:0]            w_trial;
    logic [gmi_pkg::DP_W:0]            w_diff;
    logic                              w_ge;
    logic [gmi_pkg::DP_W-1:0]          n_rem;
    logic [gmi_pkg::PROD_W-1:0]        n_quo;
    logic signed [gmi_pkg::PROD_W:0]   w_qs;
    logic signed [gmi_pkg::SUM_W-1:0]  w_sum;
    logic [gmi_pkg::SUM_W-GW:0]        w_top;
    logic signed [GW-1:0]              n_res;

    gmi_ram #(
        .WIDTH (gmi_pkg::ENTRY_W),
        .DEPTH (gmi_pkg::MAP_DEPTH)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[gmi_pkg::ADDR_W-1:0]),
        .i_wdata ({r_x, r_gin}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_rd)
    );

    assign w_rd_phys = w_rd[gmi_pkg::ENTRY_W-1:GW];
    assign w_rd_gen  = w_rd[GW-1:0];

    // Load rules: reject, zero skip, repeat skip once two points are held, then full.
    always_comb begin
        if (r_gin <= gmi_pkg::REJECT_LIMIT) begin
            w_load_st = gmi_pkg::ST_REJECTED;
        end else if (r_gin == '0) begin
            w_load_st = gmi_pkg::ST_SKIPPED;
        end else if (r_cnt >= gmi_pkg::CNT_TWO && r_gin == r_last_gen) begin
            w_load_st = gmi_pkg::ST_SKIPPED;
        end else if (r_cnt >= gmi_pkg::CNT_FULL) begin
            w_load_st = gmi_pkg::ST_FULL;
        end else begin
            w_load_st = gmi_pkg::ST_STORED;
        end
    end

    always_comb begin
        case (r_func)
            gmi_pkg::FUNC_LOAD:  w_exec_st = w_load_st;
            gmi_pkg::FUNC_QUERY: w_exec_st = gmi_pkg::ST_FEW;
            gmi_pkg::FUNC_CLEAR: w_exec_st = gmi_pkg::ST_STORED;
            default:             w_exec_st = gmi_pkg::ST_SKIPPED;
        endcase
    end

    assign w_we = (i_cmd.op == gmi_pkg::OP_EXEC) && (r_func == gmi_pkg::FUNC_LOAD) &&
                  (w_load_st == gmi_pkg::ST_STORED);

    // Segment operands. Register a holds the lower point, the RAM output the upper one.
    // Past the end, the offset and base come from the previous answered query.
    always_comb begin
        w_past   = (i_cmd.op == gmi_pkg::OP_PAST);
        w_dg     = {w_rd_gen[GW-1], w_rd_gen} - {r_ga[GW-1], r_ga};
        w_dg_abs = w_dg[GW] ? -w_dg : w_dg;
        w_xo     = w_past ? r_prev_phys : r_pa;
        w_dx     = {1'b0, r_x} - {1'b0, w_xo};
        w_dx_abs = w_dx[PW] ? -w_dx : w_dx;
        w_dp     = {1'b0, w_rd_phys} - {1'b0, r_pa};
        w_dp_abs = w_dp[PW] ? -w_dp : w_dp;
        case (i_cmd.op)
            gmi_pkg::OP_BEFORE: w_seg_st = gmi_pkg::ST_BEFORE;
            gmi_pkg::OP_PAST:   w_seg_st = gmi_pkg::ST_PAST;
            default:            w_seg_st = gmi_pkg::ST_INTERP;
        endcase
    end

    // One restoring division step: the remainder stays below the divisor magnitude.
    always_comb begin
        w_trial = {r_rem, r_quo[gmi_pkg::PROD_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dp_mag});
        w_diff  = w_trial - {1'b0, r_dp_mag};
        n_rem   = w_ge ? w_diff[gmi_pkg::DP_W-1:0] : w_trial[gmi_pkg::DP_W-1:0];
        n_quo   = {r_quo[gmi_pkg::PROD_W-2:0], w_ge};
    end

    // Signed quotient plus base, saturated to the output width.
    always_comb begin
        w_qs  = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        w_sum = {{(gmi_pkg::SUM_W-GW){r_base[GW-1]}}, r_base} + {w_qs[gmi_pkg::PROD_W], w_qs};
        w_top = w_sum[gmi_pkg::SUM_W-1:GW-1];
        if ((&w_top) || !(|w_top)) begin
            n_res = w_sum[GW-1:0];
        end else if (w_sum[gmi_pkg::SUM_W-1]) begin
            n_res = gmi_pkg::GEN_MIN;
        end else begin
            n_res = gmi_pkg::GEN_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_prev_phys <= '0;
            r_prev_gen  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == gmi_pkg::OP_EXEC && r_func == gmi_pkg::FUNC_CLEAR) begin
                r_cnt       <= '0;
                r_prev_phys <= '0;
                r_prev_gen  <= '0;
            end else if (w_we) begin
                r_cnt <= r_cnt + gmi_pkg::CNT_ONE;
            end
            if (i_cmd.op == gmi_pkg::OP_FINISH && r_func == gmi_pkg::FUNC_QUERY &&
                r_st != gmi_pkg::ST_FEW) begin
                r_prev_phys <= r_x;
                r_prev_gen  <= r_res;
            end
            if (i_cmd.op == gmi_pkg::OP_FINISH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_last_gen <= r_gin;
        end
        case (i_cmd.op)
            gmi_pkg::OP_CAPTURE: begin
                r_func <= gmi_pkg::t_func'(i_func);
                r_x    <= i_phys_pos;
                r_gin  <= i_map_genetic;
            end
            gmi_pkg::OP_EXEC: begin
                r_res <= '0;
                r_st  <= w_exec_st;
            end
            gmi_pkg::OP_FIRST: begin
                r_pa <= w_rd_phys;
                r_ga <= w_rd_gen;
                r_g0 <= w_rd_gen;
            end
            gmi_pkg::OP_SHIFT: begin
                r_pa <= w_rd_phys;
                r_ga <= w_rd_gen;
            end
            gmi_pkg::OP_BEFORE, gmi_pkg::OP_SEG, gmi_pkg::OP_PAST: begin
                r_base    <= w_past ? r_prev_gen : r_ga;
                r_neg     <= w_dg[GW] ^ w_dx[PW] ^ w_dp[PW];
                r_dg_mag  <= w_dg_abs[gmi_pkg::DG_W-1:0];
                r_dx_mag  <= w_dx_abs[gmi_pkg::DX_W-1:0];
                r_dp_mag  <= w_dp_abs[gmi_pkg::DP_W-1:0];
                r_dp_zero <= (w_dp == '0);
                r_st      <= w_seg_st;
            end
            gmi_pkg::OP_G0: begin
                r_res <= r_g0;
                r_st  <= gmi_pkg::ST_INTERP;
            end
            gmi_pkg::OP_MUL: begin
                // A zero-width segment answers its base value with no division.
                r_quo <= r_dp_zero ? '0 :
                         gmi_pkg::PROD_W'(r_dg_mag) * gmi_pkg::PROD_W'(r_dx_mag);
                r_rem <= '0;
            end
            gmi_pkg::OP_DIV: begin
                r_quo <= n_quo;
                r_rem <= n_rem;
            end
            gmi_pkg::OP_ADD: begin
                r_res <= n_res;
            end
            gmi_pkg::OP_FINISH: begin
                r_out_gen <= r_res;
                r_out_st  <= r_st;
            end
            default: begin
                r_quo <= r_quo;
            end
        endcase
    end

    always_comb begin
        o_stat.is_query = (r_func == gmi_pkg::FUNC_QUERY);
        o_stat.few      = (r_cnt < gmi_pkg::CNT_TWO);
        o_stat.x_le_pa  = (r_x <= r_pa);
        o_stat.x_le_pb  = (r_x <= w_rd_phys);
        o_stat.dp_zero  = r_dp_zero;
        o_stat.out_free = !r_out_valid || i_out_ready;
        o_stat.cnt      = r_cnt;
    end

    assign o_out_valid   = r_out_valid;
    assign o_genetic_out = r_out_gen;
    assign o_status      = r_out_st;

endmodule

`default_nettype wire

// ===== hw/rtl/genetic_map_interpolator.sv =====
// Loads, clears, unused codes and queries on fewer than two points skip the scan and arithmetic.
// A query answered from a table segment reads one table entry per cycle during the scan,
// then a bit-serial divider runs after the multiply.
// A zero-width segment skips the divider; a query at or below a later point skips both.
// A finished result waits in the output register while the next beat is accepted.
// Synchronous active-low reset empties the map and clears the previous-query registers.
`default_nettype none

module genetic_map_interpolator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [gmi_pkg::FUNC_W-1:0]        i_func,
    input  wire logic [gmi_pkg::POS_W-1:0]         i_phys_pos,
    input  wire logic signed [gmi_pkg::GEN_W-1:0]  i_map_genetic,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [gmi_pkg::GEN_W-1:0]       o_genetic_out,
    output logic [gmi_pkg::ST_W-1:0]               o_status
);

    gmi_pkg::t_dp_cmd  w_cmd;
    gmi_pkg::t_dp_stat w_stat;

    gmi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    gmi_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_func        (i_func),
        .i_phys_pos    (i_phys_pos),
        .i_map_genetic (i_map_genetic),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_genetic_out (o_genetic_out),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/gmi_chk.sv =====
// Port-level checker for the genetic map interpolator, bound to the top level.
`default_nettype none

module gmi_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_ready,
    input wire logic [gmi_pkg::FUNC_W-1:0]        i_func,
    input wire logic [gmi_pkg::POS_W-1:0]         i_phys_pos,
    input wire logic signed [gmi_pkg::GEN_W-1:0]  i_map_genetic,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_ready,
    input wire logic signed [gmi_pkg::GEN_W-1:0]  o_genetic_out,
    input wire logic [gmi_pkg::ST_W-1:0]          o_status
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_genetic_out) && $stable(o_status))
        else $error("result beat changed while stalled");

    // Every item passes through dispatch before ready returns, so ready drops right after an accepted beat.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted on consecutive cycles");

    // Only answered queries carry a genetic value.
    a_zero_non_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == gmi_pkg::ST_STORED || o_status == gmi_pkg::ST_SKIPPED ||
                        o_status == gmi_pkg::ST_REJECTED || o_status == gmi_pkg::ST_FULL ||
                        o_status == gmi_pkg::ST_FEW)
        |-> o_genetic_out == '0)
        else $error("nonzero genetic value on a non-query result");

endmodule

bind genetic_map_interpolator gmi_chk u_gmi_chk (.*);

`default_nettype wire
